### rtl/core/psc_pkg.sv
package psc_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    // coordinate, difference, cross product and divider widths
    localparam int CW  = 32;
    localparam int DW  = CW + 1;
    localparam int XW  = 2 * DW + 2;
    localparam int QW  = 34;
    localparam int PW  = XW + QW - 1 + DW;
    localparam int RW  = XW;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_SEG   = 2'd1,
        KIND_POINT = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CK_NONE     = 2'd0,
        CK_INSTABLE = 2'd1,
        CK_REVERSAL = 2'd2,
        CK_UNUSED   = 2'd3
    } t_cross_kind;

    // one lane of the divider chain
    typedef struct packed {
        logic          valid;
        logic [RW-1:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] quo;
    } t_div_lane;

endpackage

### rtl/core/psc_if.sv
interface psc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [5:0]         vertex_index;
    logic [1:0]         vertex_kind;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;

    modport source (output valid, kind, vertex_index, vertex_kind, ax, ay, bx, by,
                    input ready);
    modport sink   (input valid, kind, vertex_index, vertex_kind, ax, ay, bx, by,
                    output ready);
endinterface

interface psc_out_if;
    logic               valid;
    logic               ready;
    logic               crossed;
    logic [5:0]         edge_index;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic [1:0]         cross_kind;
    logic               inside_res;
    logic               status;

    modport source (output valid, crossed, edge_index, cross_x, cross_y, cross_kind,
                    inside_res, status, input ready);
    modport sink   (input valid, crossed, edge_index, cross_x, cross_y, cross_kind,
                    inside_res, status, output ready);
endinterface

### rtl/core/psc_div_cell.sv
module psc_div_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [psc_pkg::RW-1:0]  i_den,
    input  psc_pkg::t_div_lane      i_lane,
    output psc_pkg::t_div_lane      o_lane
);

    logic [psc_pkg::RW-1:0] trial;
    logic                   take;
    psc_pkg::t_div_lane     r_lane;

    // one restoring step: bring down the next numerator bit
    always_comb begin
        trial = {i_lane.rem[psc_pkg::RW-2:0], i_lane.low[psc_pkg::QW-1]};
        take  = (trial >= i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= i_lane.valid;
        end
        r_lane.rem <= take ? trial - i_den : trial;
        r_lane.low <= {i_lane.low[psc_pkg::QW-2:0], 1'b0};
        r_lane.quo <= {i_lane.quo[psc_pkg::QW-2:0], take};
    end

    assign o_lane = r_lane;

endmodule

### rtl/core/psc_divider.sv
module psc_divider (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [psc_pkg::PW-1:0]  i_num,
    input  logic [psc_pkg::RW-1:0]  i_den,
    output logic                    o_valid,
    output logic [psc_pkg::QW-1:0]  o_quo
);

    psc_pkg::t_div_lane lanes [psc_pkg::QW+1];

    always_comb begin
        lanes[0].valid = i_valid;
        lanes[0].rem   = psc_pkg::RW'(i_num[psc_pkg::PW-1:psc_pkg::QW]);
        lanes[0].low   = i_num[psc_pkg::QW-1:0];
        lanes[0].quo   = '0;
    end

    // one cell per quotient bit, the divisor stays put while a pair passes
    for (genvar g = 0; g < psc_pkg::QW; g++) begin : g_cell
        psc_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_den  (i_den),
            .i_lane (lanes[g]),
            .o_lane (lanes[g+1])
        );
    end

    assign o_valid = lanes[psc_pkg::QW].valid;
    assign o_quo   = lanes[psc_pkg::QW].quo;

endmodule

### rtl/core/polygon_segment_crossing_top.sv
// vertex write and unused kind go straight to the result; segment and point queries walk
// the edges, and a skew segment hit also passes the divider chain
// throughput: one word at a time, the edge walk reads one vertex per edge from the table
// and shares one 33x33 multiplier; crossing coordinates pass a 34-cell divider chain
// reset: synchronous active low, clears control and vertex_count; the vertex table is
// not cleared and holds garbage until written
module polygon_segment_crossing_top #(
    parameter int MAX_VERTICES = psc_pkg::MAX_VERTICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    psc_in_if.sink      i_in,
    psc_out_if.source   o_res
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW = psc_pkg::DW;
    localparam int XW = psc_pkg::XW;
    localparam int QW = psc_pkg::QW;
    localparam int PW = psc_pkg::PW;

    typedef enum logic [3:0] {
        S_IDLE, S_GET0, S_EDGE, S_MUL, S_TEST, S_PTEST, S_PM, S_DIV, S_DONE
    } t_state;

    // vertex table
    logic signed [31:0] mem_x [MAX_VERTICES];
    logic signed [31:0] mem_y [MAX_VERTICES];
    logic [1:0]         mem_k [MAX_VERTICES];
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] r_rdx, r_rdy;
    logic [1:0]         r_rdk;

    t_state             r_state;
    logic [6:0]         r_vc;
    logic [AW-1:0]      r_edges, r_i;
    logic               r_seg;

    // query and edge operands
    logic signed [31:0] r_qx, r_qy;
    logic signed [DW-1:0] r_vx, r_vy, r_ux, r_uy, r_wx, r_wy;
    logic signed [31:0] r_e1x, r_e1y, r_e2x, r_e2y;
    logic [1:0]         r_e1k, r_e2k;

    // shared multiplier and accumulators
    logic [2:0]         r_k;
    logic signed [2*DW-1:0] r_prod;
    logic               r_pv, r_pneg;
    logic [1:0]         r_ptgt;
    logic signed [XW-1:0] r_acc0, r_acc1, r_acc2;

    // crossing point products and divider bookkeeping
    logic [2*QW-2:0]    r_plo, r_phi;
    logic               r_negx, r_negy, r_gotx;
    logic [QW-1:0]      r_qxres;

    // pending result
    logic               p_crossed, p_inside, p_status;
    logic [5:0]         p_edge;
    logic [31:0]        p_cx, p_cy;
    logic [1:0]         p_ck;

    // output register
    logic               r_ov, r_oc, r_oi, r_os;
    logic [5:0]         r_oe;
    logic [31:0]        r_ox, r_oy;
    logic [1:0]         r_ok;

    function automatic logic between(input logic signed [31:0] a, input logic signed [31:0] p,
                                     input logic signed [31:0] b);
        return (a <= p && p <= b) || (a >= p && p >= b);
    endfunction

    function automatic logic [1:0] kind_of(input logic [1:0] k0, input logic [1:0] k1);
        logic rev;
        rev = (k0 == 2'd2) || (k1 == 2'd2) || (k0[1] && k1[1]);
        return rev ? psc_pkg::CK_REVERSAL : psc_pkg::CK_INSTABLE;
    endfunction

    // edge count from the register, clipped to the table
    logic [31:0]   vc_eff;
    logic [AW-1:0] edges_now;
    always_comb begin
        vc_eff    = (32'(r_vc) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : 32'(r_vc);
        edges_now = (vc_eff == 32'd0) ? '0 : AW'(vc_eff - 32'd1);
    end

    logic [AW-1:0] i_next;
    logic          last_edge;
    assign i_next    = AW'(r_i + 1'b1);
    assign last_edge = (i_next == r_edges);

    assign i_in.ready = (r_state == S_IDLE);
    logic in_acc;
    assign in_acc = i_in.valid && i_in.ready;

    // segment query on a single point, and whether the word needs an edge walk
    logic seg_point, walk;
    assign seg_point = (i_in.kind == psc_pkg::KIND_SEG) && (i_in.ax == i_in.bx) &&
                       (i_in.ay == i_in.by);
    assign walk      = (((i_in.kind == psc_pkg::KIND_SEG) && !seg_point) ||
                        (i_in.kind == psc_pkg::KIND_POINT)) && (edges_now != '0);

    always_comb begin
        unique case (r_state)
            S_GET0:          rd_addr = AW'(1);
            S_TEST, S_PTEST: rd_addr = AW'(r_i + 2'd2);
            default:         rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.kind == psc_pkg::KIND_WRITE &&
            32'(i_in.vertex_index) < 32'(MAX_VERTICES)) begin
            mem_x[AW'(i_in.vertex_index)] <= i_in.ax;
            mem_y[AW'(i_in.vertex_index)] <= i_in.ay;
            mem_k[AW'(i_in.vertex_index)] <= i_in.vertex_kind;
        end
        r_rdx <= mem_x[rd_addr];
        r_rdy <= mem_y[rd_addr];
        r_rdk <= mem_k[rd_addr];
    end

    // shared multiplier operand select
    logic signed [DW-1:0]   mul_a, mul_b;
    logic signed [2*DW-1:0] mul_p;
    logic [1:0]             mul_tgt;
    logic                   mul_neg;
    logic [2:0]             mul_n;
    always_comb begin
        mul_n = r_seg ? 3'd6 : 3'd2;
        mul_a = r_ux; mul_b = r_vy; mul_tgt = 2'd0; mul_neg = 1'b0;
        if (r_seg) begin
            unique case (r_k)
                3'd0:    begin mul_a = r_ux; mul_b = r_vy; mul_tgt = 2'd0; mul_neg = 1'b0; end
                3'd1:    begin mul_a = r_uy; mul_b = r_vx; mul_tgt = 2'd0; mul_neg = 1'b1; end
                3'd2:    begin mul_a = r_vx; mul_b = r_wy; mul_tgt = 2'd1; mul_neg = 1'b0; end
                3'd3:    begin mul_a = r_vy; mul_b = r_wx; mul_tgt = 2'd1; mul_neg = 1'b1; end
                3'd4:    begin mul_a = r_ux; mul_b = r_wy; mul_tgt = 2'd2; mul_neg = 1'b0; end
                default: begin mul_a = r_uy; mul_b = r_wx; mul_tgt = 2'd2; mul_neg = 1'b1; end
            endcase
        end else begin
            // (ax-xi)*dy and (ay-yi)*(xj-xi), with w = vertex - query
            if (r_k == 3'd0) begin
                mul_a = r_wx; mul_b = r_uy; mul_tgt = 2'd0; mul_neg = 1'b1;
            end else begin
                mul_a = r_wy; mul_b = r_ux; mul_tgt = 2'd1; mul_neg = 1'b1;
            end
        end
        mul_p = mul_a * mul_b;
    end

    logic signed [XW-1:0] prod_ext;
    assign prod_ext = {{(XW-2*DW){r_prod[2*DW-1]}}, r_prod};

    // segment test on the finished cross products
    logic                 t_neg;
    logic signed [XW-1:0] t_d, t_n, t_m;
    logic                 skew_hit, col_hit, pt_edge;
    logic signed [DW:0]   c_b, c_a0, c_a1, c_amin, c_amax;
    logic signed [31:0]   c_rx, c_ry;
    always_comb begin
        t_neg = r_acc0[XW-1];
        t_d   = t_neg ? -r_acc0 : r_acc0;
        t_n   = t_neg ? -r_acc1 : r_acc1;
        t_m   = t_neg ? -r_acc2 : r_acc2;
        skew_hit = !t_n[XW-1] && (t_n <= t_d) && !t_m[XW-1] && (t_m <= t_d);
        pt_edge  = (r_ux == '0) && (r_uy == '0);
        if (r_vx != '0) begin
            c_b  = {r_vx[DW-1], r_vx};
            c_a0 = {r_wx[DW-1], r_wx};
            c_a1 = (DW+1)'(signed'({r_e2x[31], r_e2x}) - signed'({r_qx[31], r_qx}));
        end else begin
            c_b  = {r_vy[DW-1], r_vy};
            c_a0 = {r_wy[DW-1], r_wy};
            c_a1 = (DW+1)'(signed'({r_e2y[31], r_e2y}) - signed'({r_qy[31], r_qy}));
        end
        if (c_b < 0) begin
            c_b  = -c_b;
            c_a0 = -c_a0;
            c_a1 = -c_a1;
        end
        if (c_a0 <= c_a1) begin
            c_amin = c_a0; c_amax = c_a1; c_rx = r_e1x; c_ry = r_e1y;
        end else begin
            c_amin = c_a1; c_amax = c_a0; c_rx = r_e2x; c_ry = r_e2y;
        end
        if (c_amin < 0) begin
            c_rx = r_qx;
            c_ry = r_qy;
        end
        if (r_acc1 != '0 || r_acc2 != '0) begin
            col_hit = 1'b0;
        end else if (pt_edge) begin
            col_hit = (r_vx != '0) ? between(r_qx, r_e1x, 32'(r_qx + r_vx))
                                   : between(r_qy, r_e1y, 32'(r_qy + r_vy));
        end else begin
            col_hit = !(c_amin > c_b || c_amax < 0);
        end
        if (pt_edge) begin
            c_rx = r_e1x;
            c_ry = r_e1y;
        end
    end

    // point test: crossing of the +x ray
    logic p_span, p_hit;
    always_comb begin
        p_span = (r_e1y <= r_qy && r_e2y > r_qy) || (r_e1y > r_qy && r_e2y <= r_qy);
        p_hit  = p_span && ((r_uy > 0 && r_acc0 < r_acc1) || (r_uy < 0 && r_acc0 > r_acc1));
    end

    // crossing point partial products, n split in two halves
    logic signed [DW-1:0] pm_comp;
    logic [DW-1:0]        pm_mag;
    logic [QW-1:0]        pm_half;
    logic [2*QW-2:0]      pm_prod;
    logic [PW-1:0]        pm_num;
    always_comb begin
        pm_comp = (r_k < 3'd3) ? r_ux : r_uy;
        pm_mag  = pm_comp[DW-1] ? DW'(-pm_comp) : DW'(pm_comp);
        pm_half = (r_k == 3'd0 || r_k == 3'd3) ? r_acc1[QW-1:0] : QW'(r_acc1[XW-1:QW]);
        pm_prod = (2*QW-1)'(pm_half * pm_mag);
        pm_num  = (PW'(r_phi) << QW) + PW'(r_plo);
    end

    logic          div_in_v, div_out_v;
    logic [QW-1:0] div_quo;
    assign div_in_v = (r_state == S_PM) && (r_k == 3'd2 || r_k == 3'd5);

    psc_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(div_in_v),
        .i_num  (pm_num),
        .i_den  (r_acc0),
        .o_valid(div_out_v),
        .o_quo  (div_quo)
    );

    logic [31:0] off_x, off_y;
    assign off_x = r_negx ? 32'(-r_qxres) : r_qxres[31:0];
    assign off_y = r_negy ? 32'(-div_quo) : div_quo[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vc    <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
            r_gotx  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vc <= i_cfg_data;
            end
            // a new word loads in S_DONE, which also covers the drain
            if (o_res.valid && o_res.ready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        p_crossed <= 1'b0;
                        p_inside  <= 1'b0;
                        p_status  <= seg_point;
                        p_edge    <= (i_in.kind == psc_pkg::KIND_SEG) ? 6'(edges_now) : '0;
                        p_cx      <= '0;
                        p_cy      <= '0;
                        p_ck      <= psc_pkg::CK_NONE;
                        r_edges   <= edges_now;
                        r_i       <= '0;
                        r_qx      <= i_in.ax;
                        r_qy      <= i_in.ay;
                        r_vx      <= DW'(signed'({i_in.bx[31], i_in.bx}) -
                                         signed'({i_in.ax[31], i_in.ax}));
                        r_vy      <= DW'(signed'({i_in.by[31], i_in.by}) -
                                         signed'({i_in.ay[31], i_in.ay}));
                        r_seg     <= (i_in.kind == psc_pkg::KIND_SEG);
                        r_state   <= walk ? S_GET0 : S_DONE;
                    end
                end
                S_GET0: begin
                    r_e1x   <= r_rdx;
                    r_e1y   <= r_rdy;
                    r_e1k   <= r_rdk;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_e2x   <= r_rdx;
                    r_e2y   <= r_rdy;
                    r_e2k   <= r_rdk;
                    r_ux    <= DW'(signed'({r_rdx[31], r_rdx}) - signed'({r_e1x[31], r_e1x}));
                    r_uy    <= DW'(signed'({r_rdy[31], r_rdy}) - signed'({r_e1y[31], r_e1y}));
                    r_wx    <= DW'(signed'({r_e1x[31], r_e1x}) - signed'({r_qx[31], r_qx}));
                    r_wy    <= DW'(signed'({r_e1y[31], r_e1y}) - signed'({r_qy[31], r_qy}));
                    r_acc0  <= '0;
                    r_acc1  <= '0;
                    r_acc2  <= '0;
                    r_k     <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // product of step k is registered and added in the next cycle
                    r_pv   <= (r_k < mul_n);
                    r_prod <= mul_p;
                    r_ptgt <= mul_tgt;
                    r_pneg <= mul_neg;
                    r_k    <= r_k + 3'd1;
                    if (r_pv) begin
                        unique case (r_ptgt)
                            2'd0:    r_acc0 <= r_pneg ? r_acc0 - prod_ext : r_acc0 + prod_ext;
                            2'd1:    r_acc1 <= r_pneg ? r_acc1 - prod_ext : r_acc1 + prod_ext;
                            default: r_acc2 <= r_pneg ? r_acc2 - prod_ext : r_acc2 + prod_ext;
                        endcase
                    end
                    if (r_k == mul_n) begin
                        r_state <= r_seg ? S_TEST : S_PTEST;
                    end
                end
                S_TEST: begin
                    r_k    <= '0;
                    r_acc0 <= t_d;
                    r_acc1 <= t_n;
                    r_negx <= r_ux[DW-1];
                    r_negy <= r_uy[DW-1];
                    r_gotx <= 1'b0;
                    if (r_acc0 == '0 ? col_hit : skew_hit) begin
                        p_crossed <= 1'b1;
                        p_edge    <= 6'(r_i);
                        p_ck      <= kind_of(r_e1k, r_e2k);
                        p_cx      <= c_rx;
                        p_cy      <= c_ry;
                        r_state   <= (r_acc0 == '0) ? S_DONE : S_PM;
                    end else if (last_edge) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= i_next;
                        r_e1x   <= r_e2x;
                        r_e1y   <= r_e2y;
                        r_e1k   <= r_e2k;
                        r_state <= S_EDGE;
                    end
                end
                S_PTEST: begin
                    if (p_hit) begin
                        p_inside <= !p_inside;
                    end
                    if (last_edge) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= i_next;
                        r_e1x   <= r_e2x;
                        r_e1y   <= r_e2y;
                        r_e1k   <= r_e2k;
                        r_state <= S_EDGE;
                    end
                end
                S_PM: begin
                    if (r_k == 3'd0 || r_k == 3'd3) begin
                        r_plo <= pm_prod;
                    end
                    if (r_k == 3'd1 || r_k == 3'd4) begin
                        r_phi <= pm_prod;
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd5) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_out_v) begin
                        if (!r_gotx) begin
                            r_qxres <= div_quo;
                            r_gotx  <= 1'b1;
                        end else begin
                            p_cx    <= r_e1x + off_x;
                            p_cy    <= r_e1y + off_y;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov    <= 1'b1;
                        r_oc    <= p_crossed;
                        r_oe    <= p_edge;
                        r_ox    <= p_cx;
                        r_oy    <= p_cy;
                        r_ok    <= p_ck;
                        r_oi    <= p_inside;
                        r_os    <= p_status;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.crossed    = r_oc;
    assign o_res.edge_index = r_oe;
    assign o_res.cross_x    = r_ox;
    assign o_res.cross_y    = r_oy;
    assign o_res.cross_kind = r_ok;
    assign o_res.inside_res = r_oi;
    assign o_res.status     = r_os;

endmodule

### rtl/core/psc_checker.sv
module psc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_crossed,
    input logic [31:0] i_cross_x,
    input logic [31:0] i_cross_y,
    input logic [1:0]  i_cross_kind,
    input logic        i_inside,
    input logic        i_status
);

    // a waiting word is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // one word in flight
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word taken while busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_crossed |-> i_cross_x == 32'd0 && i_cross_y == 32'd0 &&
                                      i_cross_kind == psc_pkg::CK_NONE)
        else $error("crossing fields set without a crossing");

    a_hit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_crossed |-> i_cross_kind != psc_pkg::CK_NONE && !i_status)
        else $error("crossing without a crossing type");

    a_point_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> !i_crossed && !i_inside)
        else $error("point segment reports a result");

endmodule

bind polygon_segment_crossing_top psc_checker u_psc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_crossed    (o_res.crossed),
    .i_cross_x    (o_res.cross_x),
    .i_cross_y    (o_res.cross_y),
    .i_cross_kind (o_res.cross_kind),
    .i_inside     (o_res.inside_res),
    .i_status     (o_res.status)
);
